// ===== design/bmd_pkg.sv =====
package bmd_pkg;

  localparam int RND_W  = 31;
  localparam int STEP_W = 5;
  localparam int ELEM_W = 7;
  localparam int CNT_W  = 8;
  localparam int CFG_W  = 8;
  localparam int ELEM_CFG_W = 7;

  localparam logic [ELEM_W-1:0] NO_ELEMENT = 7'h7F;

  localparam logic REG_TRIAL_LIMIT   = 1'b0;
  localparam logic REG_ELEMENT_COUNT = 1'b1;

  typedef struct packed {
    logic init;
    logic draw;
    logic shift;
  } cell_ctrl_t;

endpackage

// ===== design/bmd_cell.sv =====
module bmd_cell #(
  parameter int IDX = 0,
  parameter int EW  = 6,
  parameter int CW  = 7
) (
  input  logic                    clk,
  input  bmd_pkg::cell_ctrl_t     ctrl,
  input  logic [CW-1:0]           pos,
  input  logic [bmd_pkg::CNT_W-1:0] limit,
  input  logic [EW-1:0]           next_element,
  input  logic [bmd_pkg::CNT_W-1:0] next_count,
  output logic [EW-1:0]           element,
  output logic [bmd_pkg::CNT_W-1:0] count,
  output logic [EW-1:0]           sel_element,
  output logic                    remove_hit
);

  localparam logic [CW-1:0] MY_POS  = CW'(IDX);
  localparam logic [EW-1:0] MY_ELEM = EW'(IDX);

  logic                      sel;
  logic                      at_or_after;
  logic [bmd_pkg::CNT_W-1:0] count_inc;

  assign sel         = (pos == MY_POS);
  assign at_or_after = (MY_POS >= pos);
  assign count_inc   = count + 1'b1;
  assign remove_hit  = sel && (count_inc == limit);
  assign sel_element = sel ? element : '0;

  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      element <= MY_ELEM;
      count   <= '0;
    end else if (ctrl.draw) begin
      if (ctrl.shift && at_or_after) begin
        element <= next_element;
        count   <= next_count;
      end else if (sel) begin
        count <= count_inc;
      end
    end
  end

endmodule

// ===== design/bmd_div.sv =====
module bmd_div #(
  parameter int CW = 7
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [bmd_pkg::RND_W-1:0] dividend,
  input  logic [CW-1:0]             divisor,
  output logic                      done,
  output logic [CW-1:0]             remainder
);

  logic                       running;
  logic [bmd_pkg::STEP_W-1:0] step;
  logic [bmd_pkg::RND_W-1:0]  quot;
  logic [CW:0]                trial;
  logic                       fits;

  assign trial = {remainder, quot[bmd_pkg::RND_W-1]};
  assign fits  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start && !running) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + 1'b1;
        if (step == bmd_pkg::STEP_W'(bmd_pkg::RND_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !running) begin
      quot      <= dividend;
      remainder <= '0;
    end else if (running) begin
      quot <= {quot[bmd_pkg::RND_W-2:0], 1'b0};
      if (fits) begin
        remainder <= CW'(trial - {1'b0, divisor});
      end else begin
        remainder <= trial[CW-1:0];
      end
    end
  end

endmodule

// ===== design/bounded_multiset_draw.sv =====
// channel  direction  tdata                          tuser
// s_axis   in         [30:0] random_value, [31] zero  restart
// m_axis   out        [6:0] drawn_element, [7] zero   bucket_empty
// cfg      in         cfg_index 0 trial_limit, 1 element_count; cfg_data [7:0]
// A draw passes a decode state, the one-bit-per-cycle remainder unit, a state that takes
// its done flag and the cell row update, which registers the result when the output is free.
// A restart or a draw on an empty bucket gives its result from the decode state, once the
// output is free.
// rst is synchronous: bucket empty, trial_limit 1, element_count 64.
// One transaction is in flight at a time; a result held by m_tready stalls
// completion, and s_tready returns once the result is registered.
module bounded_multiset_draw #(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [30:0] random_value
  input  logic        s_tuser,   // [0] restart
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [6:0] drawn_element
  output logic        m_tuser,   // [0] bucket_empty
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int CAP = (MAX_ELEMENTS > 127) ? 127 : MAX_ELEMENTS;
  localparam int CW  = $clog2(CAP + 1);
  localparam int EW  = $clog2(CAP);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_UPD  = 4'b1000
  } state_t;

  state_t state;

  logic                              in_restart;
  logic [bmd_pkg::RND_W-1:0]         in_rnd;
  logic [CW-1:0]                     live;
  logic [bmd_pkg::CNT_W-1:0]         trial_limit;
  logic [bmd_pkg::ELEM_CFG_W-1:0]    element_count;
  logic [CW-1:0]                     fill_count;
  logic                              out_free;
  logic                              out_set;
  logic                              div_start;
  logic                              div_done;
  logic [CW-1:0]                     pos;
  bmd_pkg::cell_ctrl_t               ctrl;
  logic                              remove_any;
  logic [EW-1:0]                     drawn;

  logic [EW-1:0]                     cell_element [CAP+1];
  logic [bmd_pkg::CNT_W-1:0]         cell_count   [CAP+1];
  logic [EW-1:0]                     cell_sel     [CAP];
  logic [CAP-1:0]                    cell_remove;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign out_set  = out_free &&
                    (((state == ST_EXEC) && (in_restart || (live == '0))) ||
                     (state == ST_UPD));
  assign fill_count = (element_count > bmd_pkg::ELEM_CFG_W'(CAP)) ?
                      CW'(CAP) : CW'(element_count);
  assign div_start  = (state == ST_EXEC) && !in_restart && (live != '0);

  assign ctrl.init  = (state == ST_EXEC) && in_restart && out_free;
  assign ctrl.draw  = (state == ST_UPD) && out_free;
  assign ctrl.shift = ctrl.draw && remove_any;

  assign remove_any = |cell_remove;

  always_comb begin
    drawn = '0;
    for (int i = 0; i < CAP; i++) begin
      drawn = drawn | cell_sel[i];
    end
  end

  assign cell_element[CAP] = '0;
  assign cell_count[CAP]   = '0;

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    bmd_cell #(
      .IDX(i),
      .EW (EW),
      .CW (CW)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .pos         (pos),
      .limit       (trial_limit),
      .next_element(cell_element[i+1]),
      .next_count  (cell_count[i+1]),
      .element     (cell_element[i]),
      .count       (cell_count[i]),
      .sel_element (cell_sel[i]),
      .remove_hit  (cell_remove[i])
    );
  end

  bmd_div #(
    .CW(CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (in_rnd),
    .divisor  (live),
    .done     (div_done),
    .remainder(pos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      trial_limit   <= bmd_pkg::CNT_W'(1);
      element_count <= bmd_pkg::ELEM_CFG_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        bmd_pkg::REG_TRIAL_LIMIT:   trial_limit   <= cfg_data;
        bmd_pkg::REG_ELEMENT_COUNT: element_count <= cfg_data[bmd_pkg::ELEM_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_restart <= s_tuser;
      in_rnd     <= s_tdata[bmd_pkg::RND_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      live  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (in_restart) begin
            if (out_free) begin
              live  <= fill_count;
              state <= ST_IDLE;
            end
          end else if (live == '0) begin
            if (out_free) begin
              state <= ST_IDLE;
            end
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (out_free) begin
            if (remove_any) begin
              live <= live - 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_set) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_set) begin
      if (state == ST_UPD) begin
        m_tdata <= {1'b0, bmd_pkg::ELEM_W'(drawn)};
        m_tuser <= 1'b0;
      end else begin
        m_tdata <= {1'b0, bmd_pkg::NO_ELEMENT};
        m_tuser <= !in_restart;
      end
    end
  end

endmodule

// ===== design/bmd_checker.sv =====
module bmd_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_empty_none: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[6:0] == bmd_pkg::NO_ELEMENT)
    else $error("empty bucket result carries an element");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second transaction taken while one is in flight");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[7])
    else $error("result padding bit set");

endmodule

bind bounded_multiset_draw bmd_checker u_bmd_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);
